>>> sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants and controller/datapath interface types for the bitmap
// first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int POOL_UNITS    = 8192;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (POOL_UNITS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int MAP_SPAN      = MAP_WORDS * MAP_WORD_BITS;

  // field widths of the transaction ports
  localparam int LEN_W = 14;
  localparam int OFF_W = 13;

  // unit positions (and exclusive run ends) inside the map
  localparam int U_W   = $clog2(MAP_SPAN + 1);
  // run lengths and sums of a position and a length
  localparam int RUN_W = ((U_W > LEN_W) ? U_W : LEN_W) + 1;
  // start plus length of an incoming free, before clipping
  localparam int SUM_W = RUN_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic load;       // capture the transaction
    logic scan_rd;    // read map word at the scan pointer
    logic scan_eval;  // evaluate the word read last cycle
    logic mark_rd;    // read the partial word at the mark pointer
    logic mark_wr;    // merge and write back the partial word
    logic mark_fill;  // write a word the run covers completely
    logic resp_ok;
    logic resp_fail;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic alloc_bad;
    logic free_empty;
    logic hit;
    logic scan_last;
    logic mark_full;
    logic mark_last;
  } bffa_stat_t;

endpackage

>>> sv/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// First-fit contiguous allocator over an occupancy bitmap of pool units.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high while busy is low. operation
//   selects allocate (run_length units, first fit from unit 0) or free
//   (run_length units from run_start, clipped at the pool end).
//   Exactly one result follows per transaction: done is high for one cycle
//   with status and granted_offset valid. The receiver cannot stall; the
//   result must be taken in that cycle.
// Sequence:
//   Allocate: request check, a scan over the map words in order (up to
//   256 words, ending at the first fit), then the mark sweep. Free:
//   request check, then the sweep. The sweep writes each word the run
//   covers fully directly and reads a partially covered word before
//   merging and writing it back. A failed search ends after the last map
//   word. A new transaction can be accepted in the cycle its predecessor's
//   result is shown.
// Reset:
//   Synchronous, active high. Per-word valid bits clear at once so the map
//   reads as all free; there is no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             operation,
  input  logic [LEN_W-1:0] run_length,
  input  logic [OFF_W-1:0] run_start,
  output logic             done,
  output logic             status,
  output logic [OFF_W-1:0] granted_offset
);

  bffa_cmd_t  cmd;
  bffa_stat_t stat;

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bffa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .run_length     (run_length),
    .run_start      (run_start),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset)
  );

endmodule

>>> sv/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer for the allocator: checks the request, steps the word scan and
// the mark sweep, and issues the response.
// ----------------------------------------------------------------------------
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  bffa_stat_t stat,
  output bffa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_MARK_WR,
    S_RESP,
    S_FAIL
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_free) begin
          if (stat.alloc_bad) begin
            state_next = S_FAIL;
          end else begin
            cmd.scan_rd = 1'b1;
            state_next  = S_SCAN;
          end
        end else if (stat.free_empty) begin
          state_next = S_RESP;
        end else begin
          state_next = S_MARK;
        end
      end
      S_SCAN: begin
        cmd.scan_eval = 1'b1;
        cmd.scan_rd   = 1'b1;
        if (stat.hit) begin
          state_next = S_MARK;
        end else if (stat.scan_last) begin
          state_next = S_FAIL;
        end
      end
      S_MARK: begin
        if (stat.mark_full) begin
          cmd.mark_fill = 1'b1;
          if (stat.mark_last) state_next = S_RESP;
        end else begin
          cmd.mark_rd = 1'b1;
          state_next  = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = stat.mark_last ? S_RESP : S_MARK;
      end
      S_RESP: begin
        cmd.resp_ok = 1'b1;
        state_next  = S_IDLE;
      end
      S_FAIL: begin
        cmd.resp_fail = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  // read-modify-write always comes from a mark step that saw a partial word
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK_WR |-> $past(state) == S_MARK)
    else $error("merge write without a preceding read");

  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ($past(state) == S_CHECK || $past(state) == S_SCAN))
    else $error("scan entered from an unexpected state");

  a_hit_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.hit) |=> state == S_MARK)
    else $error("found run not marked");

endmodule

>>> sv/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// Occupancy map memory with per-word valid bits, the one-word-per-cycle
// first-fit search and the run mark/clear sweep.
// ----------------------------------------------------------------------------
module bffa_datapath
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bffa_cmd_t        cmd,
  output bffa_stat_t       stat,
  input  logic             operation,
  input  logic [LEN_W-1:0] run_length,
  input  logic [OFF_W-1:0] run_start,
  output logic             done,
  output logic             status,
  output logic [OFF_W-1:0] granted_offset
);

  // map storage; a word that was never written reads as all free
  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     map_valid;
  logic [MAP_WORD_BITS-1:0] rdata;
  logic                     rdata_ok;

  logic             op_q;
  logic [LEN_W-1:0] len_q;
  logic             alloc_bad;
  logic             free_empty;

  logic [WORD_AW-1:0] scan_addr;
  logic [WORD_AW-1:0] eval_addr;
  logic [RUN_W-1:0]   carry;
  logic [U_W-1:0]     lo;
  logic [U_W-1:0]     hi;
  logic [WORD_AW-1:0] mark_addr;

  // ---------------- load-time checks on the incoming transaction -----------
  logic [SUM_W-1:0] free_sum;
  logic [U_W-1:0]   free_hi;
  logic             free_empty_in;
  logic             alloc_bad_in;

  always_comb begin
    free_sum      = SUM_W'(run_start) + SUM_W'(run_length);
    free_hi       = (free_sum > SUM_W'(POOL_UNITS)) ? U_W'(POOL_UNITS) : U_W'(free_sum);
    free_empty_in = (SUM_W'(run_start) >= SUM_W'(POOL_UNITS)) || (run_length == '0);
    alloc_bad_in  = (run_length == '0) || (SUM_W'(run_length) > SUM_W'(POOL_UNITS));
  end

  // ---------------- scan evaluation of one word ----------------------------
  logic [MAP_WORD_BITS-1:0] scan_word;
  logic [MAP_WORD_BITS-1:0] used;
  logic [MAP_WORD_BITS-1:0] hitv;
  logic [MAP_WORD_BITS-1:0] top_free;
  logic [U_W-1:0]           scan_base;
  logic [U_W-1:0]           hit_start;
  logic [RUN_W-1:0]         carry_next;
  logic                     hit;

  always_comb begin
    logic             win_used;
    logic [RUN_W-1:0] hit_pos;
    scan_word = rdata_ok ? rdata : '0;
    scan_base = U_W'(eval_addr) * U_W'(MAP_WORD_BITS);
    // units past the pool end count as used
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      used[b] = scan_word[b] || ((scan_base + U_W'(b)) >= U_W'(POOL_UNITS));
    end
    // a run ends at bit b when the len_q units up to b are free, counting
    // free units carried over from earlier words
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      win_used = 1'b0;
      for (int j = 0; j <= b; j++) begin
        if (LEN_W'(b - j) < len_q) win_used = win_used | used[j];
      end
      hitv[b] = !win_used && ((carry + RUN_W'(b + 1)) >= RUN_W'(len_q));
    end
    hit     = |hitv;
    hit_pos = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (hitv[b]) hit_pos = RUN_W'(b);
    end
    hit_start = U_W'(RUN_W'(scan_base) + hit_pos + RUN_W'(1) - RUN_W'(len_q));
    // free units at the top of this word carry into the next one
    for (int k = 0; k < MAP_WORD_BITS; k++) begin
      top_free[k] = ((used >> (MAP_WORD_BITS - 1 - k)) == '0);
    end
    if (used == '0) carry_next = carry + RUN_W'(MAP_WORD_BITS);
    else            carry_next = RUN_W'($countones(top_free));
  end

  // ---------------- mark sweep word mask -----------------------------------
  logic [U_W-1:0]           mark_base;
  logic [MAP_WORD_BITS-1:0] mark_mask;
  logic [MAP_WORD_BITS-1:0] merged;
  logic [MAP_WORD_BITS-1:0] old_word;
  logic                     mark_last;

  always_comb begin
    logic [U_W-1:0] u;
    mark_base = U_W'(mark_addr) * U_W'(MAP_WORD_BITS);
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      u            = mark_base + U_W'(b);
      mark_mask[b] = (u >= lo) && (u < hi);
    end
    mark_last = (RUN_W'(mark_base) + RUN_W'(MAP_WORD_BITS)) >= RUN_W'(hi);
    old_word  = rdata_ok ? rdata : '0;
    merged    = (op_q == OP_ALLOC) ? (old_word | mark_mask) : (old_word & ~mark_mask);
  end

  always_comb begin
    stat.is_free    = (op_q == OP_FREE);
    stat.alloc_bad  = alloc_bad;
    stat.free_empty = free_empty;
    stat.hit        = hit;
    stat.scan_last  = (eval_addr == WORD_AW'(MAP_WORDS - 1));
    stat.mark_full  = (mark_mask == '1);
    stat.mark_last  = mark_last;
  end

  // ---------------- map memory ---------------------------------------------
  logic                     map_we;
  logic [MAP_WORD_BITS-1:0] map_wdata;
  logic [WORD_AW-1:0]       map_raddr;

  always_comb begin
    map_we    = cmd.mark_wr || cmd.mark_fill;
    map_wdata = cmd.mark_fill ? ((op_q == OP_ALLOC) ? '1 : '0) : merged;
    map_raddr = cmd.mark_rd ? mark_addr : scan_addr;
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[mark_addr] <= map_wdata;
    rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      rdata_ok  <= 1'b0;
    end else begin
      if (map_we) map_valid[mark_addr] <= 1'b1;
      rdata_ok <= map_valid[map_raddr];
    end
  end

  // ---------------- transaction registers ----------------------------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= operation;
      len_q      <= run_length;
      alloc_bad  <= alloc_bad_in;
      free_empty <= free_empty_in;
      scan_addr  <= '0;
      carry      <= '0;
      lo         <= U_W'(run_start);
      hi         <= free_hi;
      mark_addr  <= WORD_AW'(U_W'(run_start) / MAP_WORD_BITS);
    end else begin
      if (cmd.scan_rd) begin
        scan_addr <= scan_addr + WORD_AW'(1);
        eval_addr <= scan_addr;
      end
      if (cmd.scan_eval) begin
        carry <= carry_next;
        if (hit) begin
          lo        <= hit_start;
          hi        <= U_W'(RUN_W'(hit_start) + RUN_W'(len_q));
          mark_addr <= WORD_AW'(hit_start / MAP_WORD_BITS);
        end
      end
      if (map_we) mark_addr <= mark_addr + WORD_AW'(1);
    end
  end

  // ---------------- response -----------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp_ok || cmd.resp_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_ok || cmd.resp_fail) begin
      status         <= cmd.resp_fail ? ST_FAIL : ST_OK;
      granted_offset <= (cmd.resp_ok && op_q == OP_ALLOC) ? OFF_W'(lo) : '0;
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  a_mask_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark_wr || cmd.mark_fill) |-> (mark_mask != '0))
    else $error("mark sweep wrote a word outside the run");

  a_fail_is_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FAIL) |-> (op_q == OP_ALLOC))
    else $error("failure reported on a free transaction");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_first_fit_allocator. A bit-level occupancy
// map in the bench predicts each reply (first-fit search, mark, clipped
// clear); replies are compared in order against the predicted ones. Directed
// edge cases come first, then random allocate/free traffic under varying
// sender idle rates.
// ----------------------------------------------------------------------------
module testbench
  import bffa_pkg::*;
();

  typedef struct {
    logic             status;
    logic [OFF_W-1:0] offset;
  } alloc_reply_t;

  typedef struct {
    int first;
    int units;
  } granted_run_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             operation;
  logic [LEN_W-1:0] run_length;
  logic [OFF_W-1:0] run_start;
  logic             done;
  logic             status;
  logic [OFF_W-1:0] granted_offset;

  bit           unit_in_use [POOL_UNITS];
  alloc_reply_t expected_replies[$];
  granted_run_t live_runs[$];
  int           mismatch_count;
  int           send_idle_pct;

  bitmap_first_fit_allocator i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .run_length     (run_length),
    .run_start      (run_start),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_reply(input alloc_reply_t rep);
    expected_replies.insert(expected_replies.size(), rep);
  endfunction

  function automatic void keep_run(input granted_run_t run);
    live_runs.insert(live_runs.size(), run);
  endfunction

  // first-fit search or clipped clear over the bench copy of the map; updates the map
  function automatic alloc_reply_t predict_reply(input logic op,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [OFF_W-1:0] first);
    alloc_reply_t rep;
    granted_run_t run;
    int           need;
    int           run_begin;
    int           stop;
    bit           found;
    rep.status = ST_OK;
    rep.offset = '0;
    need       = int'(len);
    run_begin  = 0;
    found      = 1'b0;
    if (op == OP_ALLOC) begin
      if (need != 0 && need <= POOL_UNITS) begin
        for (int u = 0; u < POOL_UNITS && !found; u++) begin
          if (unit_in_use[u]) run_begin = u + 1;
          else if (u - run_begin + 1 == need) found = 1'b1;
        end
      end
      if (found) begin
        for (int u = run_begin; u < run_begin + need; u++) unit_in_use[u] = 1'b1;
        rep.offset = OFF_W'(run_begin);
        run.first  = run_begin;
        run.units  = need;
        keep_run(run);
      end else begin
        rep.status = ST_FAIL;
      end
    end else if (int'(first) < POOL_UNITS && need != 0) begin
      stop = int'(first) + need;
      if (stop > POOL_UNITS) stop = POOL_UNITS;
      for (int u = int'(first); u < stop; u++) unit_in_use[u] = 1'b0;
    end
    return rep;
  endfunction

  function automatic int sender_gap();
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    return gap;
  endfunction

  // drive one transaction, return at the edge that accepts it
  task automatic send_item(input logic op, input int len, input int first);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    run_length <= LEN_W'(len);
    run_start  <= OFF_W'(first);
    do @(posedge clk); while (busy);
    queue_reply(predict_reply(op, LEN_W'(len), OFF_W'(first)));
  endtask

  // hold off the sender until every reply is back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    alloc_reply_t exp_rep;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d offset=%0d", $time, status,
                 granted_offset);
        mismatch_count++;
      end else begin
        exp_rep = expected_replies.pop_front();
        if (status !== exp_rep.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rep.status,
                   status);
          mismatch_count++;
        end
        if (granted_offset !== exp_rep.offset) begin
          $display("%0t: granted_offset expected %0d actual %0d", $time,
                   exp_rep.offset, granted_offset);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_size_edges();
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 16383, 8191);
    send_item(OP_ALLOC, POOL_UNITS + 1, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, POOL_UNITS, 0);    // unit 0 taken: no run
    send_item(OP_FREE, 1, 0);
    send_item(OP_ALLOC, POOL_UNITS, 0);    // whole pool
    send_item(OP_ALLOC, 1, 0);             // pool full
  endtask

  task automatic test_free_edges();
    send_item(OP_FREE, 16383, 8191);       // clipped at pool end
    send_item(OP_FREE, 0, 0);              // clears nothing
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_FREE, POOL_UNITS, 0);
    send_item(OP_FREE, 50, 100);           // units not in use
  endtask

  task automatic test_word_crossing();
    send_item(OP_ALLOC, 31, 0);
    send_item(OP_ALLOC, 33, 0);
    send_item(OP_ALLOC, 5, 0);
    send_item(OP_FREE, 20, 10);
    wait_drained();
    send_item(OP_ALLOC, 21, 0);            // hole too small, goes past the end
    send_item(OP_ALLOC, 20, 0);            // exact fit in the hole
    send_item(OP_FREE, 16383, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int           pick;
    int           len;
    int           idx;
    granted_run_t run;
    send_idle_pct = idle_pct;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (live_runs.size() > 40 && pick < 50) pick = 60;
      if (pick < 50) begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(48, 1);
        else if (pick < 95) len = $urandom_range(600, 49);
        else if (pick < 99) len = $urandom_range(4096, 601);
        else len = $urandom_range(POOL_UNITS, 4097);
        send_item(OP_ALLOC, len, $urandom_range(8191));
      end else if (pick < 90 && live_runs.size() != 0) begin
        idx = $urandom_range(live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        if ($urandom_range(4) == 0) len = $urandom_range(run.units);
        else len = run.units;
        send_item(OP_FREE, len, run.first);
      end else begin
        case ($urandom_range(3))
          0: send_item(OP_ALLOC, $urandom_range(16383), $urandom_range(8191));
          1: send_item(OP_FREE, $urandom_range(16383), $urandom_range(8191));
          2: send_item(OP_FREE, $urandom_range(64), $urandom_range(8191));
          default: send_item(OP_ALLOC, 0, $urandom_range(8191));
        endcase
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    operation      = OP_ALLOC;
    run_length     = '0;
    run_start      = '0;
    mismatch_count = 0;
    send_idle_pct  = 30;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_size_edges();
    test_free_edges();
    test_word_crossing();
    wait_drained();
    test_random_traffic(410, 30);
    wait_drained();
    test_random_traffic(410, 74);
    wait_drained();
    test_random_traffic(410, 0);
    wait_drained();
    repeat (600) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
